/* hdl/lzss_pkg.sv */
// Shared types and constants for the LZSS stream decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps

package lzss_pkg;

    // History ring geometry
    localparam int          RING_AW   = 12;
    localparam logic [11:0] START_POS = 12'd4078;
    localparam logic [7:0]  SPACE     = 8'h20;
    localparam logic [4:0]  MIN_MATCH = 5'd3;

    // Parser phase of the front end
    typedef enum logic [1:0] {
        PH_FLAG,
        PH_UNIT,
        PH_HIGH,
        PH_DONE
    } phase_t;

    // One decode command: a literal word or a copy from the ring
    typedef struct packed {
        logic                is_lit;
        logic [7:0]          lit_byte;
        logic [RING_AW-1:0]  pos;
        logic [3:0]          len_code;
    } cmd_t;

endpackage

/* hdl/lzss_front.sv */
// Front end of the LZSS decoder: parses compressed words into commands.
// Depends on lzss_pkg (phase_t, cmd_t).
`timescale 1ns / 1ps

module lzss_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        data_byte,
    input  logic              in_last,
    input  logic              q_full,
    output logic              push,
    output lzss_pkg::cmd_t    push_cmd
);
    import lzss_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] flags_reg, flags_next;
    logic [7:0]  pend_reg, pend_next;
    logic        accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FLAG;
            flags_reg <= 16'd0;
            pend_reg  <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            pend_reg  <= pend_next;
        end
    end

    // Classify each accepted word
    always_comb
    begin
        phase_next        = phase_reg;
        flags_next        = flags_reg;
        pend_next         = pend_reg;
        push              = 1'b0;
        push_cmd.is_lit   = 1'b1;
        push_cmd.lit_byte = data_byte;
        push_cmd.pos      = {data_byte[7:4], pend_reg};
        push_cmd.len_code = data_byte[3:0];
        if (accept)
        begin
            unique case (phase_reg)
                PH_FLAG:
                begin
                    flags_next = {8'hFF, data_byte};
                    phase_next = PH_UNIT;
                end
                PH_UNIT:
                begin
                    if (flags_reg[0])
                    begin
                        push       = 1'b1;
                        flags_next = {1'b0, flags_reg[15:1]};
                        phase_next = flags_reg[9] ? PH_UNIT : PH_FLAG;
                    end
                    else
                    begin
                        pend_next  = data_byte;
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    push            = 1'b1;
                    push_cmd.is_lit = 1'b0;
                    flags_next      = {1'b0, flags_reg[15:1]};
                    phase_next      = flags_reg[9] ? PH_UNIT : PH_FLAG;
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
            // stream end: ignore everything until reset
            if (in_last)
            begin
                phase_next = PH_DONE;
            end
        end
    end

endmodule

/* hdl/lzss_cmd_fifo.sv */
// Small command queue between the parser and the copy engine.
// Depends on lzss_pkg (cmd_t).
`timescale 1ns / 1ps

module lzss_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lzss_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output lzss_pkg::cmd_t    head_cmd
);
    import lzss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = slot_reg[rptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and count update
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/lzss_back.sv */
// Back end of the LZSS decoder: history ring, copy engine, capacity check,
// output register. Depends on lzss_pkg (cmd_t, ring constants).
`timescale 1ns / 1ps

module lzss_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       capacity,
    input  logic              cmd_valid,
    input  lzss_pkg::cmd_t    cmd,
    output logic              cmd_pop,
    output logic              failed,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic              overflow
);
    import lzss_pkg::*;

    localparam int RING_DEPTH = 1 << RING_AW;

    logic [7:0] ring_mem [RING_DEPTH];

    // Sequencer stage: current command
    logic               cur_v_reg, cur_v_next;
    logic               cur_lit_reg, cur_lit_next;
    logic [7:0]         cur_byte_reg, cur_byte_next;
    logic [RING_AW-1:0] cur_pos_reg, cur_pos_next;
    logic [4:0]         cur_rem_reg, cur_rem_next;

    // Data stage: one word in flight, ring read data behind it
    logic               d_v_reg, d_v_next;
    logic               d_lit_reg, d_lit_next;
    logic               d_byp_reg, d_byp_next;
    logic               d_fill_reg, d_fill_next;
    logic               d_last_reg, d_last_next;
    logic [7:0]         d_byte_reg, d_byte_next;
    logic [7:0]         rd_q_reg;

    // Ring write side and counters
    logic [RING_AW-1:0] wp_reg, wp_next;
    logic [RING_AW:0]   wcnt_reg, wcnt_next;
    logic [31:0]        bytes_reg, bytes_next;
    logic               failed_reg, failed_next;

    // Output register
    logic               out_v_reg, out_v_next;
    logic [7:0]         out_byte_reg;
    logic               out_last_reg, out_ovf_reg;

    logic               d_adv, fail_now, wr_en, rd_en, issue, cur_done, load;
    logic [7:0]         d_data;
    logic [RING_AW-1:0] rel_pos;
    logic               filled, bypass;

    assign d_adv    = d_v_reg && (!out_v_reg || !out_stall);
    assign fail_now = d_adv && (bytes_reg >= capacity);
    assign wr_en    = d_adv && !fail_now;
    assign d_data   = (d_lit_reg || d_byp_reg) ? d_byte_reg :
                      (d_fill_reg ? rd_q_reg : SPACE);

    assign issue    = cur_v_reg && !failed_reg && (!d_v_reg || d_adv) && !fail_now;
    assign cur_done = issue && (cur_lit_reg || (cur_rem_reg == 5'd1));
    assign cmd_pop  = cmd_valid && (failed_reg || !cur_v_reg || cur_done);
    assign load     = cmd_pop && !failed_reg;
    assign rd_en    = issue && !cur_lit_reg;

    // Entry never written since reset still reads as space
    assign rel_pos  = cur_pos_reg - START_POS;
    assign filled   = wcnt_reg[RING_AW] || (rel_pos < wcnt_reg[RING_AW-1:0]);
    // Copy reading the word written in the same cycle
    assign bypass   = wr_en && (wp_reg == cur_pos_reg);

    assign failed    = failed_reg;
    assign out_valid = out_v_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign overflow  = out_ovf_reg;

    // Sequencer next state
    always_comb
    begin
        cur_v_next    = cur_v_reg;
        cur_lit_next  = cur_lit_reg;
        cur_byte_next = cur_byte_reg;
        cur_pos_next  = cur_pos_reg;
        cur_rem_next  = cur_rem_reg;
        if (issue)
        begin
            cur_pos_next = cur_pos_reg + 1'b1;
            cur_rem_next = cur_rem_reg - 1'b1;
            if (cur_done)
            begin
                cur_v_next = 1'b0;
            end
        end
        if (load)
        begin
            cur_v_next    = 1'b1;
            cur_lit_next  = cmd.is_lit;
            cur_byte_next = cmd.lit_byte;
            cur_pos_next  = cmd.pos;
            cur_rem_next  = {1'b0, cmd.len_code} + MIN_MATCH;
        end
        if (failed_reg || fail_now)
        begin
            cur_v_next = 1'b0;
        end
    end

    // Data stage next state
    always_comb
    begin
        d_v_next    = d_v_reg;
        d_lit_next  = d_lit_reg;
        d_byp_next  = d_byp_reg;
        d_fill_next = d_fill_reg;
        d_last_next = d_last_reg;
        d_byte_next = d_byte_reg;
        if (issue)
        begin
            d_v_next    = 1'b1;
            d_lit_next  = cur_lit_reg;
            d_byp_next  = bypass;
            d_fill_next = filled;
            d_last_next = cur_done;
            d_byte_next = cur_lit_reg ? cur_byte_reg : d_data;
        end
        else if (d_adv)
        begin
            d_v_next = 1'b0;
        end
        if (failed_reg || fail_now)
        begin
            d_v_next = 1'b0;
        end
    end

    // Ring pointer, fill count, byte count, failure
    always_comb
    begin
        wp_next     = wp_reg;
        wcnt_next   = wcnt_reg;
        bytes_next  = bytes_reg;
        failed_next = failed_reg || fail_now;
        if (wr_en)
        begin
            wp_next    = wp_reg + 1'b1;
            bytes_next = bytes_reg + 32'd1;
            if (!wcnt_reg[RING_AW])
            begin
                wcnt_next = wcnt_reg + 1'b1;
            end
        end
    end

    // Output register valid
    always_comb
    begin
        if (d_adv)
        begin
            out_v_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_v_next = 1'b0;
        end
        else
        begin
            out_v_next = out_v_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_v_reg  <= 1'b0;
            d_v_reg    <= 1'b0;
            wp_reg     <= START_POS;
            wcnt_reg   <= '0;
            bytes_reg  <= 32'd0;
            failed_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            cur_v_reg  <= cur_v_next;
            d_v_reg    <= d_v_next;
            wp_reg     <= wp_next;
            wcnt_reg   <= wcnt_next;
            bytes_reg  <= bytes_next;
            failed_reg <= failed_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_lit_reg  <= cur_lit_next;
        cur_byte_reg <= cur_byte_next;
        cur_pos_reg  <= cur_pos_next;
        cur_rem_reg  <= cur_rem_next;
        d_lit_reg    <= d_lit_next;
        d_byp_reg    <= d_byp_next;
        d_fill_reg   <= d_fill_next;
        d_last_reg   <= d_last_next;
        d_byte_reg   <= d_byte_next;
        if (d_adv)
        begin
            out_byte_reg <= fail_now ? 8'd0 : d_data;
            out_last_reg <= fail_now ? 1'b1 : d_last_reg;
            out_ovf_reg  <= fail_now;
        end
    end

    // History ring: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wp_reg] <= d_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= ring_mem[cur_pos_reg];
        end
    end

endmodule

/* hdl/lzss_stream_decoder.sv */
// LZSS stream decoder (4096-byte window, 3..18 byte matches), top level.
// Instantiates lzss_front, lzss_cmd_fifo and lzss_back; uses lzss_pkg.
// Input channel: one compressed word per handshake (data_byte, in_last),
// taken when in_valid is high and in_stall is low. in_stall rises only
// while the command queue is full.
// Output channel: one decoded word per handshake (out_byte, out_last,
// overflow), taken when out_valid is high and out_stall is low. out_last
// marks the final word caused by one input word; overflow marks the single
// error word sent when out_capacity would be passed, after which all input
// is dropped until reset.
// Config channel: cfg_data is written into out_capacity when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// With the engine idle, a word's first output goes via the command queue,
// sequencer, data stage and output register to out_valid. The copy engine
// sends one word per cycle unless stalled: a literal gives one, a pair its
// match length (3 to 18), flag/low words none; output bytes set throughput.
// A stalled receiver holds the output register; the engine and then the
// command queue fill, and input stalls behind them.
// Reset: the ring reads as spaces until written (a fill count, no clearing
// pass), writing starts at position 4078, out_capacity returns to all ones.
`timescale 1ns / 1ps

module lzss_stream_decoder #(
    parameter int CMD_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import lzss_pkg::*;

    logic [31:0] cap_reg;
    logic        push, q_full, cmd_valid, cmd_pop, failed;
    cmd_t        push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 32'hFFFF_FFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cap_reg <= cfg_data;
        end
    end

    lzss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .in_last   (in_last),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    lzss_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (cmd_pop),
        .head_valid (cmd_valid),
        .head_cmd   (head_cmd)
    );

    lzss_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (cap_reg),
        .cmd_valid (cmd_valid),
        .cmd       (head_cmd),
        .cmd_pop   (cmd_pop),
        .failed    (failed),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .overflow  (overflow)
    );

`ifndef NO_ASSERTIONS
    // The error word always closes its input word
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> out_last)
        else $error("overflow word without out_last");

    // Once failed, the only word shown is the error word itself
    a_failed_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        failed && out_valid |-> overflow)
        else $error("decoded word after failure");

    // An empty command queue never holds off input
    a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> !in_stall)
        else $error("input stalled with empty queue");

    // After an accepted error word no further word appears
    a_ovf_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && overflow |=> !out_valid)
        else $error("word after overflow");
`endif

endmodule

/* verif/tb_lzss_stream_decoder.sv */
// Self-checking testbench for lzss_stream_decoder: directed and random streams,
// scored against a built-in model of the decoder. Depends on lzss_pkg and the RTL.
`timescale 1ns / 1ps

module tb_lzss_stream_decoder;

    import lzss_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 4000;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int {
        END_OVF_RUN,
        END_OVF_NOW,
        END_LAST_LITERAL,
        END_LAST_FLAG,
        END_LAST_LOW
    } end_kind_t;

    // One decoded word as seen on the output channel
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       ovf;
    } dec_word_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        in_last;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        overflow;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // Decoder model state
    logic [7:0]         ring_m [0:(1 << RING_AW) - 1];
    logic [RING_AW-1:0] wpos_m;
    logic [15:0]        flags_m;
    phase_t             phase_m;
    logic [7:0]         low_m;
    logic [31:0]        count_m;
    logic               failed_m;
    logic [31:0]        capacity_m;

    dec_word_t dec_q[$];

    int send_pct;
    int recv_pct;
    int words_sent;
    int errors;

    lzss_stream_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .overflow  (overflow),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ---------------------------------------------------------------
    // Decoder model
    // ---------------------------------------------------------------

    // Emit one decoded byte, or the error word once capacity is used up
    function automatic bit push_byte(input logic [7:0] b);
        dec_word_t w;
        if (count_m >= capacity_m)
        begin
            w = '{data: 8'h00, last: 1'b0, ovf: 1'b1};
            dec_q.push_back(w);
            failed_m = 1'b1;
            return 1'b0;
        end
        w = '{data: b, last: 1'b0, ovf: 1'b0};
        dec_q.push_back(w);
        count_m++;
        ring_m[wpos_m] = b;
        wpos_m = wpos_m + 1'b1;
        return 1'b1;
    endfunction

    // Consume one unit flag; a fresh flag word is due once the marker falls out
    function automatic void next_unit();
        flags_m = flags_m >> 1;
        phase_m = flags_m[8] ? PH_UNIT : PH_FLAG;
    endfunction

    function automatic void decode_word(input logic [7:0] d, input logic l);
        int                 prev_len;
        logic [RING_AW-1:0] pos;
        int                 len;
        bit                 ok;
        dec_word_t          tail;
        if (failed_m || phase_m == PH_DONE)
            return;
        prev_len = dec_q.size();
        case (phase_m)
            PH_FLAG:
            begin
                flags_m = {8'hFF, d};
                phase_m = PH_UNIT;
            end
            PH_UNIT:
            begin
                if (flags_m[0])
                begin
                    if (push_byte(d))
                        next_unit();
                end
                else
                begin
                    low_m   = d;
                    phase_m = PH_HIGH;
                end
            end
            default:
            begin
                // copy may read bytes it has just written
                pos = {d[7:4], low_m};
                len = int'(d[3:0]) + int'(MIN_MATCH);
                ok  = 1'b1;
                for (int k = 0; k < len && ok; k++)
                    ok = push_byte(ring_m[pos + RING_AW'(k)]);
                if (ok)
                    next_unit();
            end
        endcase
        if (dec_q.size() > prev_len)
        begin
            tail      = dec_q.pop_back();
            tail.last = 1'b1;
            dec_q.push_back(tail);
        end
        if (l && !failed_m)
            phase_m = PH_DONE;
    endfunction

    // ---------------------------------------------------------------
    // Channel helpers
    // ---------------------------------------------------------------

    function automatic void set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_SEND:
            begin
                send_pct = 62;
                recv_pct = 0;
            end
            IDLE_RECV:
            begin
                send_pct = 0;
                recv_pct = 62;
            end
            IDLE_BOTH:
            begin
                send_pct = 18;
                recv_pct = 18;
            end
            default:
            begin
                send_pct = 0;
                recv_pct = 0;
            end
        endcase
    endfunction

    // Send one compressed word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] d, input logic l);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        in_last   <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        decode_word(d, l);
    endtask

    task automatic send_pair(input logic [RING_AW-1:0] pos, input logic [3:0] code);
        send_word(pos[7:0], 1'b0);
        send_word({pos[11:8], code}, 1'b0);
    endtask

    // Bring the stream to a flag word boundary with random units
    task automatic complete_group();
        while (phase_m != PH_FLAG)
            send_word(8'($urandom), 1'b0);
    endtask

    // Wait until every expected word has come out, then let the pipe settle
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (dec_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        capacity_m = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // All-literal group with extreme byte values
    task automatic test_literals();
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hFE, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);
    endtask

    // All-pair group: reset spaces, longest match, self-overlapping copies
    task automatic test_copies();
        send_word(8'h00, 1'b0);
        send_pair('0, 4'h0);
        send_pair(wpos_m - 12'd8, 4'hF);
        send_pair(wpos_m, 4'h5);
        send_pair(wpos_m - 12'd1, 4'h7);
        send_pair('1, 4'hF);
        send_pair(wpos_m - 12'd3, 4'h9);
        send_pair(12'h0AA, 4'h2);
        send_pair(wpos_m - 12'd2, 4'hF);
    endtask

    // Zero capacity while only non-emitting words are in flight
    task automatic test_capacity_extremes();
        complete_group();
        write_capacity(32'h0000_0000);
        send_word(8'h00, 1'b0);
        send_word(8'($urandom), 1'b0);
        write_capacity(32'hFFFF_FFFF);
        send_word(8'($urandom), 1'b0);
    endtask

    // Well-formed random groups; idling mode rotates per group
    task automatic test_random_stream(input int count, input logic [31:0] cap);
        int         start;
        int         grp;
        logic [7:0] flag;
        write_capacity(cap);
        complete_group();
        start = words_sent;
        grp   = 0;
        while (words_sent - start < count)
        begin
            set_idling(idle_mode_t'(grp % 4));
            flag = 8'($urandom);
            send_word(flag, 1'b0);
            for (int u = 0; u < 8; u++)
            begin
                if (flag[u])
                    send_word(8'($urandom), 1'b0);
                else if ($urandom_range(0, 99) < 60)
                    send_pair(wpos_m - RING_AW'($urandom_range(1, 64)), 4'($urandom));
                else
                    send_pair(RING_AW'($urandom), 4'($urandom));
            end
            grp++;
        end
        set_idling(IDLE_NONE);
    endtask

    // Terminate the stream one way or another, then check input is dropped
    task automatic test_stream_end();
        end_kind_t kind;
        kind = end_kind_t'($urandom_range(0, 4));
        set_idling(IDLE_BOTH);
        complete_group();
        case (kind)
            END_OVF_RUN:
            begin
                // error in the middle of a long copy
                write_capacity(count_m + 32'($urandom_range(0, 17)));
                send_word(8'h00, 1'b0);
                send_pair(RING_AW'($urandom), 4'hF);
            end
            END_OVF_NOW:
            begin
                write_capacity(count_m);
                send_word(8'hFF, 1'b0);
                send_word(8'($urandom), 1'b0);
            end
            END_LAST_LITERAL:
            begin
                send_word(8'hFF, 1'b0);
                send_word(8'($urandom), 1'b1);
            end
            END_LAST_FLAG:
                send_word(8'($urandom), 1'b1);
            default:
            begin
                // pair cut short after its low word
                send_word(8'h00, 1'b0);
                send_word(8'($urandom), 1'b1);
            end
        endcase
        for (int k = 0; k < 6; k++)
            send_word(8'($urandom), (k == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
    endtask

    // ---------------------------------------------------------------
    // Output side
    // ---------------------------------------------------------------

    // Receiver stall
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_pct);

    // Compare each accepted output word with the oldest expected one
    always @(posedge clk)
    begin
        dec_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (dec_q.size() == 0)
            begin
                $error("unexpected output word: out_byte %02h out_last %0b overflow %0b",
                       out_byte, out_last, overflow);
                errors++;
            end
            else
            begin
                want = dec_q.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                    errors++;
                end
                if (out_last !== want.last)
                begin
                    $error("out_last: expected %0b, got %0b", want.last, out_last);
                    errors++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want.ovf, overflow);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too many cycles without any handshake
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = 8'h00;
        in_last    = 1'b0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = 32'h0;
        errors     = 0;
        words_sent = 0;
        set_idling(IDLE_NONE);

        for (int i = 0; i < (1 << RING_AW); i++)
            ring_m[i] = SPACE;
        wpos_m     = START_POS;
        flags_m    = '0;
        phase_m    = PH_FLAG;
        low_m      = '0;
        count_m    = '0;
        failed_m   = 1'b0;
        capacity_m = 32'hFFFF_FFFF;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_literals();
        test_copies();
        test_capacity_extremes();
        test_random_stream(50, 32'hFFFF_FFFF);
        test_random_stream(50, count_m + 32'd100000 + 32'($urandom_range(0, 1 << 20)));
        test_stream_end();
        wait_drained();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
